>>> design/hbcc_pkg.sv
// Shared types, constants and helpers for the half-block cell compositor.
package hbcc_pkg;

  localparam int unsigned RgbW   = 24;
  localparam int unsigned ChanW  = 8;
  localparam int unsigned AlphaW = 8;
  localparam int unsigned PixW   = 32;
  localparam int unsigned ProdW  = 2 * ChanW;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [ChanW-1:0] ChanMax = 8'hFF;

  localparam logic [RgbW-1:0]   DefaultUnderReset = 24'h101418;
  localparam logic [AlphaW-1:0] TransparentReset  = 8'd40;
  localparam logic [AlphaW-1:0] OpaqueReset       = 8'd200;

  typedef enum logic [CfgIdxW-1:0] {
    REG_DEFAULT_UNDER = 2'd0,
    REG_TRANSPARENT   = 2'd1,
    REG_OPAQUE        = 2'd2
  } reg_index_t;

  typedef enum logic [2:0] {
    ACT_UNTOUCHED   = 3'd0,
    ACT_FULL_UPPER  = 3'd1,
    ACT_UPPER_EDGE  = 3'd2,
    ACT_LOWER_EDGE  = 3'd3,
    ACT_TINT        = 3'd4
  } action_t;

  // Stage advance enables handed from the top level to the blend datapath.
  typedef struct packed {
    logic en2;
    logic en3;
  } stage_en_t;

  // Exact floor(s / 255) for any s up to 255 * 255.
  function automatic logic [ChanW-1:0] div255(input logic [ProdW-1:0] s);
    logic [ProdW:0] t;
    t = {1'b0, s} + {{(ProdW){1'b0}}, 1'b1} + {{(ChanW + 1){1'b0}}, s[ProdW-1:ChanW]};
    return t[ProdW-1:ChanW];
  endfunction

endpackage

>>> design/hbcc_blend.sv
// Two-stage per-channel alpha blend: products and sum, then divide by 255.
module hbcc_blend (
  input  logic                    clk,
  input  hbcc_pkg::stage_en_t     en,
  input  logic [hbcc_pkg::RgbW-1:0]   over,
  input  logic [hbcc_pkg::RgbW-1:0]   under,
  input  logic [hbcc_pkg::AlphaW-1:0] alpha,
  output logic [hbcc_pkg::RgbW-1:0]   tint
);
  import hbcc_pkg::*;

  localparam int unsigned NumChan = RgbW / ChanW;

  logic [ChanW-1:0] inv_alpha;

  assign inv_alpha = ChanMax - alpha;

  for (genvar c = 0; c < NumChan; c++) begin : g_chan
    logic [ProdW-1:0] prod_over;
    logic [ProdW-1:0] prod_under;
    logic [ProdW-1:0] sum;
    logic [ChanW-1:0] quot;

    assign prod_over  = {{ChanW{1'b0}}, over[c*ChanW +: ChanW]} * {{ChanW{1'b0}}, alpha};
    assign prod_under = {{ChanW{1'b0}}, under[c*ChanW +: ChanW]} * {{ChanW{1'b0}}, inv_alpha};

    // The two weights add to 255, so the sum never exceeds 255 * 255.
    always_ff @(posedge clk) begin
      if (en.en2) begin
        sum <= prod_over + prod_under;
      end
    end

    always_ff @(posedge clk) begin
      if (en.en3) begin
        quot <= div255(sum);
      end
    end

    assign tint[c*ChanW +: ChanW] = quot;
  end

endmodule

>>> design/halfblock_cell_compositor_unit.sv
// Top level of the half-block cell compositor: classify and blend each cell item.
// One cell can enter on every clock unless a stalled output has filled the pipeline.
// Three register stages lie between input and output: stage one compares the alphas
// and registers the action and the blend operands, stage two registers the channel
// products' sums, and stage three divides by 255 into the output register.
// Each stage advances whenever the stage after it is empty or moving, so a stalled
// output still lets earlier bubbles fill and nothing is lost or repeated.
module halfblock_cell_compositor_unit (
  input  logic        clk,
  input  logic        rst,
  // Configuration writes.
  input  logic                         cfg_we,
  input  logic [hbcc_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [hbcc_pkg::RgbW-1:0]    cfg_data,
  // Input items.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [87:0] s_axis_tdata,  // top_pixel, bottom_pixel, cell_bg_color
  input  logic        s_axis_tuser,  // cell_bg_is_rgb
  // Result items.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,  // fg_color, bg_color
  output logic [2:0]  m_axis_tuser   // action
);
  import hbcc_pkg::*;

  logic [RgbW-1:0]   default_under;
  logic [AlphaW-1:0] transparent_below;
  logic [AlphaW-1:0] opaque_above;

  always_ff @(posedge clk) begin
    if (rst) begin
      default_under     <= DefaultUnderReset;
      transparent_below <= TransparentReset;
      opaque_above      <= OpaqueReset;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DEFAULT_UNDER: default_under     <= cfg_data;
        REG_TRANSPARENT:   transparent_below <= cfg_data[AlphaW-1:0];
        REG_OPAQUE:        opaque_above      <= cfg_data[AlphaW-1:0];
        default: ;
      endcase
    end
  end

  logic [PixW-1:0] top_pixel;
  logic [PixW-1:0] bottom_pixel;
  logic [RgbW-1:0] cell_bg_color;
  logic            cell_bg_is_rgb;

  assign top_pixel      = s_axis_tdata[31:0];
  assign bottom_pixel   = s_axis_tdata[63:32];
  assign cell_bg_color  = s_axis_tdata[87:64];
  assign cell_bg_is_rgb = s_axis_tuser;

  logic      v1, v2, v3;
  stage_en_t en;
  logic      en1;

  assign en.en3 = !v3 || m_axis_tready;
  assign en.en2 = !v2 || en.en3;
  assign en1    = !v1 || en.en2;
  assign s_axis_tready = en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (en1)    v1 <= s_axis_tvalid;
      if (en.en2) v2 <= v1;
      if (en.en3) v3 <= v2;
    end
  end

  // Stage one: classify the cell.
  logic [AlphaW-1:0] a_upper;
  logic [AlphaW-1:0] a_lower;
  logic              top_op;
  logic              bot_op;
  action_t           action_next;
  logic [RgbW-1:0]   fg_next;
  logic [RgbW-1:0]   bg_next;

  assign a_upper = top_pixel[PixW-1 -: AlphaW];
  assign a_lower = bottom_pixel[PixW-1 -: AlphaW];
  assign top_op  = a_upper > opaque_above;
  assign bot_op  = a_lower > opaque_above;

  always_comb begin
    fg_next = '0;
    bg_next = '0;
    if (a_upper < transparent_below && a_lower < transparent_below) begin
      action_next = ACT_UNTOUCHED;
    end else if (top_op && bot_op) begin
      action_next = ACT_FULL_UPPER;
      fg_next     = top_pixel[RgbW-1:0];
      bg_next     = bottom_pixel[RgbW-1:0];
    end else if (top_op) begin
      action_next = ACT_UPPER_EDGE;
      fg_next     = top_pixel[RgbW-1:0];
    end else if (bot_op) begin
      action_next = ACT_LOWER_EDGE;
      fg_next     = bottom_pixel[RgbW-1:0];
    end else begin
      action_next = ACT_TINT;
    end
  end

  action_t           action1, action2, action3;
  logic [RgbW-1:0]   fg1, fg2, fg3;
  logic [RgbW-1:0]   bg1, bg2, bg3;
  logic [RgbW-1:0]   over1;
  logic [RgbW-1:0]   under1;
  logic [AlphaW-1:0] alpha1;
  logic [RgbW-1:0]   tint;

  always_ff @(posedge clk) begin
    if (en1) begin
      action1 <= action_next;
      fg1     <= fg_next;
      bg1     <= bg_next;
      over1   <= top_pixel[RgbW-1:0];
      under1  <= cell_bg_is_rgb ? cell_bg_color : default_under;
      alpha1  <= (a_upper > a_lower) ? a_upper : a_lower;
    end
  end

  hbcc_blend u_blend (
    .clk   (clk),
    .en    (en),
    .over  (over1),
    .under (under1),
    .alpha (alpha1),
    .tint  (tint)
  );

  always_ff @(posedge clk) begin
    if (en.en2) begin
      action2 <= action1;
      fg2     <= fg1;
      bg2     <= bg1;
    end
    if (en.en3) begin
      action3 <= action2;
      fg3     <= fg2;
      bg3     <= bg2;
    end
  end

  assign m_axis_tvalid = v3;
  assign m_axis_tuser  = action3;
  assign m_axis_tdata  = {(action3 == ACT_TINT) ? tint : bg3, fg3};

endmodule

>>> sim/halfblock_cell_compositor_unit_test.sv
// Self-checking testbench for the half-block cell compositor: stream stimulus and a scoreboard.
`timescale 1ns / 100ps

module halfblock_cell_compositor_unit_test;
  import hbcc_pkg::*;

  typedef struct {
    action_t    act;
    logic [23:0] fg;
    logic [23:0] bg;
  } cell_paint_t;

  // Predicts the repaint of each accepted cell and checks results in order.
  class cell_scoreboard;
    cell_paint_t   paints_due[$];
    logic [23:0]   fallback_under;
    logic [7:0]    clear_below;
    logic [7:0]    solid_above;
    int            errors;

    function new();
      fallback_under = DefaultUnderReset;
      clear_below    = TransparentReset;
      solid_above    = OpaqueReset;
      errors         = 0;
    endfunction

    function logic [7:0] mix(logic [7:0] over, logic [7:0] under, logic [7:0] a);
      int unsigned s;
      s = int'(over) * int'(a) + int'(under) * (255 - int'(a));
      return 8'(s / 255);
    endfunction

    function void note_cell(logic [31:0] top, logic [31:0] bot, bit is_rgb,
                            logic [23:0] cell_bg);
      cell_paint_t p;
      logic [7:0]  at;
      logic [7:0]  ab;
      logic [7:0]  a;
      logic [23:0] under;
      at = top[31:24];
      ab = bot[31:24];
      p.fg = '0;
      p.bg = '0;
      // The transparent test wins even when the thresholds overlap.
      if (at < clear_below && ab < clear_below) begin
        p.act = ACT_UNTOUCHED;
      end else if (at > solid_above && ab > solid_above) begin
        p.act = ACT_FULL_UPPER;
        p.fg  = top[23:0];
        p.bg  = bot[23:0];
      end else if (at > solid_above) begin
        p.act = ACT_UPPER_EDGE;
        p.fg  = top[23:0];
      end else if (ab > solid_above) begin
        p.act = ACT_LOWER_EDGE;
        p.fg  = bot[23:0];
      end else begin
        // The top colour is always blended, at whichever alpha is larger.
        a     = (at > ab) ? at : ab;
        under = is_rgb ? cell_bg : fallback_under;
        p.act = ACT_TINT;
        p.bg  = {mix(top[23:16], under[23:16], a), mix(top[15:8], under[15:8], a),
                 mix(top[7:0], under[7:0], a)};
      end
      paints_due.push_back(p);
    endfunction

    function void check_paint(logic [2:0] act, logic [23:0] fg, logic [23:0] bg);
      cell_paint_t p;
      if (paints_due.size() == 0) begin
        $display("%0t: unexpected result item: action %0d fg %h bg %h", $time, act, fg, bg);
        errors++;
        return;
      end
      p = paints_due.pop_front();
      if (act !== p.act) begin
        $display("%0t: action mismatch: expected %0d, got %0d", $time, p.act, act);
        errors++;
      end
      if (fg !== p.fg) begin
        $display("%0t: fg_color mismatch: expected %h, got %h", $time, p.fg, fg);
        errors++;
      end
      if (bg !== p.bg) begin
        $display("%0t: bg_color mismatch: expected %h, got %h", $time, p.bg, bg);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [23:0] cfg_data;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [87:0] s_axis_tdata;   // top_pixel, bottom_pixel, cell_bg_color
  logic        s_axis_tuser;   // cell_bg_is_rgb
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [47:0] m_axis_tdata;   // fg_color, bg_color
  logic [2:0]  m_axis_tuser;   // action

  cell_scoreboard sb = new();
  bit tx_steady;
  bit rx_steady;
  int rx_hold;

  halfblock_cell_compositor_unit dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("halfblock_cell_compositor_unit_test: errors");
    $finish;
  end

  // Offers one cell, after a random gap unless the sender is steady, and holds it until the block takes it.
  task automatic send_cell(logic [31:0] top, logic [31:0] bot, bit is_rgb,
                           logic [23:0] cell_bg);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {cell_bg, bot, top};
    s_axis_tuser  <= is_rgb;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_cell(top, bot, is_rgb, cell_bg);
  endtask

  // Alphas cluster around the current thresholds so that every boundary is hit.
  function automatic logic [7:0] pick_alpha();
    case ($urandom_range(0, 9))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return sb.clear_below - 8'd1;
      3:       return sb.clear_below;
      4:       return sb.solid_above;
      5:       return sb.solid_above + 8'd1;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic send_random_cells(int count);
    logic [31:0] top;
    logic [31:0] bot;
    for (int i = 0; i < count; i++) begin
      top = $urandom;
      bot = $urandom;
      top[31:24] = pick_alpha();
      bot[31:24] = pick_alpha();
      if ($urandom_range(0, 49) == 0) tx_steady = !tx_steady;
      send_cell(top, bot, 1'($urandom), 24'($urandom));
    end
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (sb.paints_due.size() != 0) @(posedge clk);
  endtask

  // Holds the write enable high; the caller drops it after the last write.
  task automatic write_reg(reg_index_t idx, logic [23:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    case (idx)
      REG_DEFAULT_UNDER: sb.fallback_under = value;
      REG_TRANSPARENT:   sb.clear_below    = value[7:0];
      REG_OPAQUE:        sb.solid_above    = value[7:0];
      default: ;
    endcase
  endtask

  // Registers change only once the pipeline has emptied.
  task automatic configure(logic [23:0] under, logic [7:0] clear, logic [7:0] solid);
    wait_drained();
    write_reg(REG_DEFAULT_UNDER, under);
    write_reg(REG_TRANSPARENT, {16'h0, clear});
    write_reg(REG_OPAQUE, {16'h0, solid});
    cfg_we <= 1'b0;
  endtask

  initial begin
    int stall;
    @(posedge clk);
    forever begin
      if (rx_hold > 0) begin
        stall   = rx_hold;
        rx_hold = 0;
      end else begin
        stall = rx_steady ? 0 : $urandom_range(0, 15);
      end
      if ($urandom_range(0, 59) == 0) rx_steady = !rx_steady;
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
      sb.check_paint(m_axis_tuser, m_axis_tdata[23:0], m_axis_tdata[47:24]);
    end
  end

  initial begin
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_index     = REG_DEFAULT_UNDER;
    cfg_data      = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    m_axis_tready = 1'b0;
    tx_steady     = 1'b0;
    rx_steady     = 1'b0;
    rx_hold       = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed cells at the reset thresholds.
    send_cell(32'h00000000, 32'h00000000, 1'b0, 24'h000000);
    send_cell(32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, 24'hFFFFFF);
    send_cell(32'hFF123456, 32'h00ABCDEF, 1'b0, 24'h5A5A5A);
    send_cell(32'h10123456, 32'hC9ABCDEF, 1'b1, 24'hA5A5A5);
    send_cell(32'h27FFFFFF, 32'h27FFFFFF, 1'b1, 24'h123456);
    send_cell(32'h27FFFFFF, 32'h28000000, 1'b0, 24'hFFFFFF);
    send_cell(32'h28FFFFFF, 32'h27000000, 1'b1, 24'h000000);
    send_cell(32'hC8FFFFFF, 32'hC8FFFFFF, 1'b1, 24'h000000);
    send_cell(32'hC9654321, 32'hC8FFFFFF, 1'b0, 24'h000000);
    send_cell(32'hC8FFFFFF, 32'hC9654321, 1'b0, 24'h000000);
    send_cell(32'h80FF00FF, 32'h90000000, 1'b1, 24'h00FF00);
    send_cell(32'hC9FFFFFF, 32'hC9000000, 1'b0, 24'hFFFFFF);
    send_cell(32'hFF000000, 32'hFFFFFFFF, 1'b1, 24'h000000);
    send_cell(32'h00FFFFFF, 32'h00FFFFFF, 1'b1, 24'hFFFFFF);
    send_cell(32'hC8FFFFFF, 32'h00000000, 1'b0, 24'h000000);
    send_cell(32'h28000000, 32'h28000000, 1'b1, 24'hFFFFFF);
    send_cell(32'hC80000FF, 32'h27FF0000, 1'b1, 24'h123456);
    send_cell(32'hFF00FF00, 32'hC9FF00FF, 1'b0, 24'h0F0F0F);

    send_random_cells(300);

    // Back-pressure: the output stalls while cells keep arriving.
    wait_drained();
    tx_steady = 1'b1;
    rx_hold   = 300;
    send_random_cells(40);

    // Nothing is transparent and nothing is opaque: every cell is tinted.
    configure(24'h000000, 8'd0, 8'd255);
    send_random_cells(125);
    // Thresholds overlap: the transparent test must win.
    configure(24'hFFFFFF, 8'd255, 8'd0);
    send_random_cells(125);
    configure(24'h800080, 8'd255, 8'd255);
    send_random_cells(125);
    configure(24'h7F7F7F, 8'd0, 8'd0);
    send_random_cells(125);
    for (int k = 0; k < 4; k++) begin
      configure(24'($urandom), 8'($urandom), 8'($urandom));
      send_random_cells(100);
    end

    wait_drained();
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.paints_due.size() == 0) begin
      $display("halfblock_cell_compositor_unit_test: clean");
    end else begin
      $display("halfblock_cell_compositor_unit_test: errors");
    end
    $finish;
  end

endmodule
